// File: design/dsfe_pkg.sv
// Shared types and constants for the DShot frame encoder.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package dsfe_pkg;

   // Frame geometry
   localparam int FRAME_SLOTS = 18;
   localparam int FRAME_BITS  = 16;
   localparam int MOTOR_COUNT = 4;
   localparam int SLOT_W      = $clog2(FRAME_SLOTS);

   // Throttle mapping
   localparam logic [15:0] THR_MIN_CMD   = 16'd1000;
   localparam logic [15:0] THR_MAX_CMD   = 16'd2000;
   localparam logic [9:0]  THR_HALF_SPAN = 10'd500;
   localparam logic [10:0] DS_MIN        = 11'd48;
   localparam logic [10:0] DS_STOP       = 11'd0;

   // Register reset
   localparam logic [11:0] BIT_PERIOD_RESET = 12'd800;

   // Frame queue between front and back
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // Command kinds
   localparam logic KIND_THROTTLE = 1'b0;
   localparam logic KIND_RAW      = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [1:0]  motor_sel;
      logic [15:0] command_value;
      logic        telem_req;
   } req_type;

   typedef struct packed {
      logic [1:0]  channel;
      logic [11:0] slot_high_ticks;
      logic        last_slot;
   } rsp_type;

   // One encoded frame waiting for the slot sequencer
   typedef struct packed {
      logic [1:0]            channel;
      logic [FRAME_BITS-1:0] bits;
   } frame_type;

   // Queue status seen by the back end
   typedef struct packed {
      logic full;
      logic valid;
   } fifo_status_type;

endpackage

`default_nettype wire

// File: design/dshot_frame_encoder.sv
// Top level of the DShot frame encoder: front end, frame queue, slot sequencer.
// Depends on dsfe_pkg, dsfe_front, dsfe_fifo and dsfe_back.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted command item yields 18 result items, one DShot bit slot each:
// the 16 frame bits MSB first with high time 3/4 or 3/8 of bit_period_ticks,
// then two zero pad slots, the last flagged by last_slot. The slot sequencer
// emits one slot per clock while its output register is free or being popped;
// the first slot of an item goes through the frame queue and the output
// register to the result ports. A two-frame queue between the front end
// and the sequencer lets new items be taken while a frame is still playing out.
// Items whose motor_sel names no motor are accepted and produce nothing.
// bit_period_ticks is written via csr_write/csr_wdata and resets to 800; write
// it only while no frame is in flight.

module dshot_frame_encoder (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_push,
   output logic              req_full,
   input  dsfe_pkg::req_type req_data,
   output logic              rsp_empty,
   input  wire               rsp_pop,
   output dsfe_pkg::rsp_type rsp_data,
   input  wire               csr_write,
   input  wire  [11:0]       csr_wdata
);
   import dsfe_pkg::*;

   logic            frame_push;
   frame_type       frame_data;
   fifo_status_type queue_status;
   frame_type       queue_head;
   logic            queue_pop;

   assign req_full = queue_status.full;

   dsfe_front u_front (
      .req_push   (req_push),
      .req_data   (req_data),
      .queue_full (queue_status.full),
      .frame_push (frame_push),
      .frame_data (frame_data)
   );

   dsfe_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (frame_push),
      .push_data (frame_data),
      .pop       (queue_pop),
      .status    (queue_status),
      .head      (queue_head)
   );

   dsfe_back u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_write),
      .csr_wdata    (csr_wdata),
      .queue_status (queue_status),
      .queue_head   (queue_head),
      .queue_pop    (queue_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_data     (rsp_data)
   );

endmodule

`default_nettype wire

// File: design/dsfe_front.sv
// Front end: accepts commands, maps throttle, builds the 16-bit DShot frame.
// Depends on dsfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsfe_front (
   input  wire               req_push,
   input  dsfe_pkg::req_type req_data,
   input  wire               queue_full,
   output logic              frame_push,
   output dsfe_pkg::frame_type frame_data
);
   import dsfe_pkg::*;

   logic        accept;
   logic        motor_ok;
   logic [15:0] cmd_clamped;
   logic [9:0]  span;
   logic [10:0] thr_value;
   logic [10:0] value11;
   logic [11:0] packet;
   logic [3:0]  checksum;

   assign accept   = req_push && !queue_full;
   assign motor_ok = int'(req_data.motor_sel) < MOTOR_COUNT;

   // Throttle map: 48 + round(span * 1999 / 1000) equals 48 + 2*span, one less past mid span
   always_comb begin
      cmd_clamped = (req_data.command_value > THR_MAX_CMD) ? THR_MAX_CMD
                                                           : req_data.command_value;
      span        = 10'(cmd_clamped - THR_MIN_CMD);
      if (req_data.command_value <= THR_MIN_CMD) begin
         thr_value = DS_STOP;
      end else begin
         thr_value = DS_MIN + {span, 1'b0} - {10'd0, (span > THR_HALF_SPAN)};
      end
   end

   // Value select, packet and XOR nibble checksum
   always_comb begin
      case (req_data.kind)
         KIND_RAW: value11 = req_data.command_value[10:0];
         default:  value11 = thr_value;
      endcase
      packet   = {value11, req_data.telem_req};
      checksum = packet[3:0] ^ packet[7:4] ^ packet[11:8];
   end

   // Items for a motor that does not exist are taken and dropped
   assign frame_push         = accept && motor_ok;
   assign frame_data.channel = req_data.motor_sel;
   assign frame_data.bits    = {packet, checksum};

endmodule

`default_nettype wire

// File: design/dsfe_fifo.sv
// Short frame queue that decouples the front end from the slot sequencer.
// Depends on dsfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsfe_fifo (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       push,
   input  dsfe_pkg::frame_type       push_data,
   input  wire                       pop,
   output dsfe_pkg::fifo_status_type status,
   output dsfe_pkg::frame_type       head
);
   import dsfe_pkg::*;

   frame_type               mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic                    do_push, do_pop;

   assign status.full  = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign status.valid = (count_ff != '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && status.valid;
   assign head         = mem_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: design/dsfe_back.sv
// Back end: slot sequencer that plays one frame out as timed slots, and the
// bit period register. Depends on dsfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsfe_back (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       csr_write,
   input  wire  [11:0]               csr_wdata,
   input  dsfe_pkg::fifo_status_type queue_status,
   input  dsfe_pkg::frame_type       queue_head,
   output logic                      queue_pop,
   output logic                      rsp_empty,
   input  wire                       rsp_pop,
   output dsfe_pkg::rsp_type         rsp_data
);
   import dsfe_pkg::*;

   logic [11:0]           period_ff;
   logic                  busy_ff, busy_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic [1:0]            chan_ff;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_ff, out_in;

   logic [FRAME_BITS-1:0] cur_frame;
   logic [1:0]            cur_chan;
   logic [SLOT_W-1:0]     cur_slot;
   logic                  have_work, advance, emit, is_last;
   logic [13:0]           period_x3;
   logic [11:0]           one_ticks, zero_ticks, hi_ticks;

   // High times: 3/4 and 3/8 of the period, truncated
   assign period_x3  = {2'b00, period_ff} + {1'b0, period_ff, 1'b0};
   assign one_ticks  = period_x3[13:2];
   assign zero_ticks = {1'b0, period_x3[13:3]};

   // Current slot comes from the frame in flight or straight from the queue head
   assign cur_frame = busy_ff ? frame_ff : queue_head.bits;
   assign cur_chan  = busy_ff ? chan_ff  : queue_head.channel;
   assign cur_slot  = busy_ff ? slot_ff  : '0;
   assign have_work = busy_ff || queue_status.valid;
   assign advance   = !out_valid_ff || rsp_pop;
   assign emit      = have_work && advance;
   assign is_last   = (cur_slot == SLOT_W'(FRAME_SLOTS - 1));
   assign queue_pop = emit && !busy_ff;

   always_comb begin
      if (int'(cur_slot) < FRAME_BITS) begin
         hi_ticks = cur_frame[FRAME_BITS-1] ? one_ticks : zero_ticks;
      end else begin
         hi_ticks = '0;
      end
   end

   // Sequencer next state
   always_comb begin
      busy_in      = busy_ff;
      slot_in      = slot_ff;
      frame_in     = frame_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_in       = out_ff;
      if (emit) begin
         out_valid_in           = 1'b1;
         out_in.channel         = cur_chan;
         out_in.slot_high_ticks = hi_ticks;
         out_in.last_slot       = is_last;
         busy_in                = !is_last;
         slot_in                = is_last ? '0 : cur_slot + 1'b1;
         frame_in               = {cur_frame[FRAME_BITS-2:0], 1'b0};
      end
   end

   // Control state and bit period register
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= BIT_PERIOD_RESET;
         busy_ff      <= 1'b0;
         slot_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            period_ff <= csr_wdata;
         end
         busy_ff      <= busy_in;
         slot_ff      <= slot_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      out_ff   <= out_in;
      if (queue_pop) begin
         chan_ff <= queue_head.channel;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTHESIS
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (slot_ff != '0) && (int'(slot_ff) < FRAME_SLOTS))
      else $error("slot counter out of range while busy");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      queue_pop |-> queue_status.valid)
      else $error("frame queue popped while empty");

   a_last_is_pad: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.last_slot && (FRAME_SLOTS > FRAME_BITS))
      |-> (out_ff.slot_high_ticks == '0))
      else $error("final slot of a frame carries a high time");

   a_frame_ends: assert property (@(posedge clock) disable iff (reset)
      (emit && is_last) |=> !busy_ff)
      else $error("sequencer still busy after the final slot");
`endif

endmodule

`default_nettype wire
